### src/okmu_pkg.sv
// Shared constants for the online k-means update core.
// No dependencies.
package okmu_pkg;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    localparam logic KIND_POINT   = 1'b0;
    localparam logic KIND_READOUT = 1'b1;

    localparam int COUNT_BITS = 32;

endpackage

### src/online_kmeans_update_core.sv
// Top level of the online k-means update core: center memories, distance walk,
// serial mean division and readout sequencer. Uses okmu_pkg.
//
// One command is taken when start is high and busy is low. A point walks the
// K centers in use for the equality and distance check; each center passes
// through a memory read state, three square states and a compare state. A point
// that equals a starting center stops at that center's first square state. Any
// other point then goes through the shared bit-serial divider for the three
// coordinates of the new mean, then a write-back state. A last point then reads
// out all K centers in use. Results appear for one cycle with valid and cannot be
// stalled; run_end marks the final result of a command.
module online_kmeans_update_core #(
    parameter int MAX_CLUSTERS = 8,
    parameter int COORD_BITS   = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [3:0]                   cfg_wdata,
    input  logic                         start,
    output logic                         busy,
    input  logic                         command,
    input  logic [2:0]                   center_index,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    input  logic                         last_point,
    output logic                         valid,
    output logic                         kind,
    output logic [2:0]                   cluster,
    output logic                         skipped,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic signed [COORD_BITS-1:0] out_z,
    output logic                         run_end
);

    localparam int IW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int KW  = $clog2(MAX_CLUSTERS + 1);
    localparam int DW  = COORD_BITS + 1;
    localparam int SQW = 2 * DW;
    localparam int SUMW = SQW + 2;
    localparam int CB  = okmu_pkg::COUNT_BITS;
    localparam int NW  = CB + 1;
    localparam int BCW = $clog2(DW + 1);
    localparam logic [CB-1:0] COUNT_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_RD, ST_SQ0, ST_SQ1, ST_SQ2, ST_CMP,
        ST_DIV, ST_WB, ST_RO_RD, ST_RO_OUT
    } state_t;

    typedef struct packed {
        logic [CB-1:0] cnt;
        logic signed [COORD_BITS-1:0] mx, my, mz;
        logic signed [COORD_BITS-1:0] sx, sy, sz;
    } entry_t;

    // center memory: one entry per cluster, synchronous read
    entry_t mem [MAX_CLUSTERS];
    entry_t rd_reg;
    logic [MAX_CLUSTERS-1:0] cnt_one_reg;  // reset marks counts as one

    state_t state_reg;
    logic [3:0] kcfg_reg;
    logic [KW-1:0] k_eff;
    logic [IW-1:0] idx_reg, best_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg, pz_reg;
    logic last_reg;
    logic [SUMW-1:0] acc_reg, best_d_reg;
    logic [DW-1:0] mag_reg;
    logic signed [COORD_BITS-1:0] bmx_reg, bmy_reg, bmz_reg;
    logic [CB-1:0] bcnt_reg;
    // divider
    logic [1:0] axis_reg;
    logic [BCW-1:0] bit_reg;
    logic [DW-1:0] dq_reg;
    logic [NW-1:0] drem_reg;
    logic dneg_reg;
    logic signed [COORD_BITS-1:0] nx_reg, ny_reg, nz_reg;

    always_comb
    begin
        if (kcfg_reg == 4'd0)
            k_eff = KW'(1);
        else if ({1'b0, kcfg_reg} > 5'(MAX_CLUSTERS))
            k_eff = KW'(MAX_CLUSTERS);
        else
            k_eff = KW'(kcfg_reg);
    end

    logic [CB-1:0] rd_cnt;
    assign rd_cnt = cnt_one_reg[idx_reg] ? CB'(1) : rd_reg.cnt;

    logic signed [DW-1:0] dsel;
    logic [DW-1:0] dmag;
    always_comb
    begin
        unique case (state_reg)
            ST_SQ1:  dsel = DW'(py_reg) - DW'(rd_reg.my);
            ST_SQ2:  dsel = DW'(pz_reg) - DW'(rd_reg.mz);
            default: dsel = DW'(px_reg) - DW'(rd_reg.mx);
        endcase
        dmag = dsel[DW-1] ? DW'(-dsel) : DW'(dsel);
    end

    logic [SQW-1:0] sq;
    assign sq = mag_reg * mag_reg;

    logic eq_start;
    assign eq_start = (rd_reg.sx == px_reg) && (rd_reg.sy == py_reg)
                   && (rd_reg.sz == pz_reg);

    // divider operands
    logic signed [COORD_BITS-1:0] dc, dp;
    logic signed [DW-1:0] ddiff;
    logic [DW-1:0] dmagd;
    logic [NW-1:0] den, trial;
    always_comb
    begin
        unique case (axis_reg)
            2'd1:    begin dc = bmy_reg; dp = py_reg; end
            2'd2:    begin dc = bmz_reg; dp = pz_reg; end
            default: begin dc = bmx_reg; dp = px_reg; end
        endcase
        ddiff = DW'(dp) - DW'(dc);
        dmagd = ddiff[DW-1] ? DW'(-ddiff) : DW'(ddiff);
        den   = NW'(bcnt_reg) + NW'(1);
        trial = {drem_reg[NW-2:0], dmagd[bit_reg[BCW-1:0] - BCW'(1)]};
    end

    // finish of one axis: c + floor((p-c)/(n+1)), plus one if negative and inexact (truncated total)
    logic signed [DW:0] qs, ssum;
    logic rnz, tge;
    logic [NW-1:0] rem_fin;
    logic signed [COORD_BITS-1:0] res_axis;
    always_comb
    begin
        tge = trial >= den;
        rem_fin = tge ? (trial - den) : trial;
        rnz = (rem_fin != '0);
        qs = (DW+1)'({1'b0, dq_reg[DW-2:0], tge});
        if (dneg_reg)
            qs = -qs - ((DW+1)'(rnz));
        ssum = (DW+1)'(dc) + qs;
        if (ssum[DW] && rnz)
            ssum = ssum + (DW+1)'(1);
        res_axis = ssum[COORD_BITS-1:0];
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_LOAD:
                mem[idx_reg] <= '{cnt: CB'(1), mx: px_reg, my: py_reg, mz: pz_reg,
                                  sx: px_reg, sy: py_reg, sz: pz_reg};
            ST_WB:
                mem[best_reg] <= '{cnt: (bcnt_reg == COUNT_MAX) ? bcnt_reg
                                        : bcnt_reg + CB'(1),
                                   mx: nx_reg, my: ny_reg, mz: nz_reg,
                                   sx: rd_reg.sx, sy: rd_reg.sy, sz: rd_reg.sz};
            ST_RO_OUT:
                mem[idx_reg] <= '{cnt: CB'(1), mx: rd_reg.mx, my: rd_reg.my,
                                  mz: rd_reg.mz, sx: rd_reg.mx, sy: rd_reg.my,
                                  sz: rd_reg.mz};
            default: ;
        endcase
        // hold the chosen entry during division so write-back keeps its start
        rd_reg <= mem[(state_reg == ST_DIV) ? best_reg : idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            kcfg_reg    <= 4'd8;
            cnt_one_reg <= '1;
            valid       <= 1'b0;
            idx_reg     <= '0;
            best_reg    <= '0;
            axis_reg    <= '0;
            bit_reg     <= BCW'(DW);
        end
        else
        begin
            valid <= 1'b0;
            if (cfg_we)
                kcfg_reg <= cfg_wdata;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        px_reg   <= coord_x;
                        py_reg   <= coord_y;
                        pz_reg   <= coord_z;
                        last_reg <= last_point;
                        if (command == okmu_pkg::CMD_LOAD)
                        begin
                            if (32'(center_index) < MAX_CLUSTERS)
                            begin
                                idx_reg   <= IW'(center_index);
                                state_reg <= ST_LOAD;
                            end
                        end
                        else
                        begin
                            idx_reg   <= '0;
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_LOAD:
                begin
                    cnt_one_reg[idx_reg] <= 1'b0;
                    state_reg <= ST_IDLE;
                end
                ST_RD:
                    state_reg <= ST_SQ0;  // memory read in flight
                ST_SQ0:
                begin
                    if (eq_start)
                    begin
                        valid     <= 1'b1;
                        kind      <= okmu_pkg::KIND_POINT;
                        cluster   <= 3'(idx_reg);
                        skipped   <= 1'b1;
                        out_x     <= '0;
                        out_y     <= '0;
                        out_z     <= '0;
                        run_end   <= !last_reg;
                        idx_reg   <= '0;
                        state_reg <= last_reg ? ST_RO_RD : ST_IDLE;
                    end
                    else
                    begin
                        mag_reg   <= dmag;
                        acc_reg   <= '0;
                        state_reg <= ST_SQ1;
                    end
                end
                ST_SQ1:
                begin
                    acc_reg   <= acc_reg + SUMW'(sq);
                    mag_reg   <= dmag;
                    state_reg <= ST_SQ2;
                end
                ST_SQ2:
                begin
                    acc_reg   <= acc_reg + SUMW'(sq);
                    mag_reg   <= dmag;
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    // strict less keeps the lower index on ties
                    if (idx_reg == '0 || (acc_reg + SUMW'(sq)) < best_d_reg)
                    begin
                        best_d_reg <= acc_reg + SUMW'(sq);
                        best_reg   <= idx_reg;
                        bmx_reg    <= rd_reg.mx;
                        bmy_reg    <= rd_reg.my;
                        bmz_reg    <= rd_reg.mz;
                        bcnt_reg   <= rd_cnt;
                    end
                    if (KW'(idx_reg) + KW'(1) == k_eff)
                    begin
                        axis_reg  <= '0;
                        bit_reg   <= BCW'(DW);
                        dq_reg    <= '0;
                        drem_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= ST_RD;
                    end
                end
                ST_DIV:
                begin
                    // restoring division, one quotient bit per cycle
                    dneg_reg <= ddiff[DW-1];
                    if (bit_reg == BCW'(1))
                    begin
                        unique case (axis_reg)
                            2'd0:    nx_reg <= res_axis;
                            2'd1:    ny_reg <= res_axis;
                            default: nz_reg <= res_axis;
                        endcase
                        dq_reg   <= '0;
                        drem_reg <= '0;
                        bit_reg  <= BCW'(DW);
                        if (axis_reg == 2'd2)
                            state_reg <= ST_WB;
                        else
                            axis_reg <= axis_reg + 2'd1;
                    end
                    else
                    begin
                        dq_reg   <= {dq_reg[DW-2:0], tge};
                        drem_reg <= rem_fin;
                        bit_reg  <= bit_reg - BCW'(1);
                    end
                end
                ST_WB:
                begin
                    cnt_one_reg[best_reg] <= 1'b0;
                    valid     <= 1'b1;
                    kind      <= okmu_pkg::KIND_POINT;
                    cluster   <= 3'(best_reg);
                    skipped   <= 1'b0;
                    out_x     <= nx_reg;
                    out_y     <= ny_reg;
                    out_z     <= nz_reg;
                    run_end   <= !last_reg;
                    idx_reg   <= '0;
                    state_reg <= last_reg ? ST_RO_RD : ST_IDLE;
                end
                ST_RO_RD:
                    state_reg <= ST_RO_OUT;
                ST_RO_OUT:
                begin
                    cnt_one_reg[idx_reg] <= 1'b0;
                    valid   <= 1'b1;
                    kind    <= okmu_pkg::KIND_READOUT;
                    cluster <= 3'(idx_reg);
                    skipped <= 1'b0;
                    out_x   <= rd_reg.mx;
                    out_y   <= rd_reg.my;
                    out_z   <= rd_reg.mz;
                    run_end <= (KW'(idx_reg) + KW'(1) == k_eff);
                    if (KW'(idx_reg) + KW'(1) == k_eff)
                        state_reg <= ST_IDLE;
                    else
                    begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= ST_RO_RD;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(state_reg) != ST_IDLE)
        else $error("result strobe without work");
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && skipped) |-> (out_x == '0 && out_y == '0 && out_z == '0))
        else $error("skipped result carries coordinates");
    a_readout_noskip: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && kind == okmu_pkg::KIND_READOUT) |-> !skipped)
        else $error("readout marked skipped");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (KW'(idx_reg) < k_eff))
        else $error("distance walk past cluster count");
`endif

endmodule

### tb/online_kmeans_update_core_tb.sv
// Testbench for online_kmeans_update_core: directed and random load/point beats,
// checked against a built-in sequential k-means predictor. Depends on okmu_pkg.
module online_kmeans_update_core_tb;

    typedef struct packed {
        logic        kind;
        logic [2:0]  cluster;
        logic        skipped;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        run_end;
    } center_result_t;

    int unsigned error_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    class kmeans_scoreboard;
        logic signed [31:0] start_c[8][3];
        logic signed [31:0] mean_c[8][3];
        logic [31:0] members[8];
        int unsigned active_k;
        center_result_t pending_results[$];

        function new();
            active_k = 8;
            for (int i = 0; i < 8; i++) members[i] = 32'd1;
        endfunction

        function void set_count(logic [3:0] v);
            active_k = (v == 4'd0) ? 1 : (v > 4'd8) ? 8 : int'(v);
        endfunction

        // c + (p-c)/(n+1), truncated toward zero overall
        function logic signed [31:0] next_mean(logic signed [31:0] c, logic signed [31:0] p,
                                               logic [31:0] n);
            longint signed num;
            longint signed den;
            longint signed q;
            num = longint'(c) * longint'({32'd0, n}) + longint'(p);
            den = longint'({32'd0, n}) + 1;
            q = num / den;
            return q[31:0];
        endfunction

        function void note_input(logic cmd, logic [2:0] idx, logic signed [31:0] px,
                                 logic signed [31:0] py, logic signed [31:0] pz, logic lastp);
            logic signed [31:0] p[3];
            center_result_t r;
            int hit;
            int best;
            logic [127:0] best_d;
            logic [127:0] d;
            logic [127:0] mag;
            longint signed diff;
            p[0] = px; p[1] = py; p[2] = pz;
            if (cmd == okmu_pkg::CMD_LOAD) begin
                for (int a = 0; a < 3; a++) begin
                    start_c[idx][a] = p[a];
                    mean_c[idx][a] = p[a];
                end
                members[idx] = 32'd1;
                return;
            end
            hit = -1;
            for (int j = 0; j < active_k; j++)
                if (hit < 0 && start_c[j][0] == px && start_c[j][1] == py && start_c[j][2] == pz)
                    hit = j;
            r = '0;
            r.kind = okmu_pkg::KIND_POINT;
            r.run_end = !lastp;
            if (hit >= 0) begin
                r.cluster = 3'(hit);
                r.skipped = 1'b1;
            end else begin
                best = 0;
                best_d = '0;
                for (int j = 0; j < active_k; j++) begin
                    d = '0;
                    for (int a = 0; a < 3; a++) begin
                        diff = longint'(mean_c[j][a]) - longint'(p[a]);
                        mag = (diff < 0) ? 128'(-diff) : 128'(diff);
                        d += mag * mag;
                    end
                    if (j == 0 || d < best_d) begin
                        best_d = d;
                        best = j;
                    end
                end
                for (int a = 0; a < 3; a++)
                    mean_c[best][a] = next_mean(mean_c[best][a], p[a], members[best]);
                if (members[best] != 32'hFFFF_FFFF) members[best]++;
                r.cluster = 3'(best);
                r.x = mean_c[best][0]; r.y = mean_c[best][1]; r.z = mean_c[best][2];
            end
            pending_results.push_back(r);
            if (lastp) begin
                for (int j = 0; j < active_k; j++) begin
                    r = '0;
                    r.kind = okmu_pkg::KIND_READOUT;
                    r.cluster = 3'(j);
                    r.x = mean_c[j][0]; r.y = mean_c[j][1]; r.z = mean_c[j][2];
                    r.run_end = (j + 1 == active_k);
                    pending_results.push_back(r);
                    for (int a = 0; a < 3; a++) start_c[j][a] = mean_c[j][a];
                    members[j] = 32'd1;
                end
            end
        endfunction

        task check_result(input center_result_t got);
            center_result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", got.x, 32'd0);
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("kind", 32'(got.kind), 32'(want.kind));
            if (got.cluster !== want.cluster)
                report_mismatch("cluster", 32'(got.cluster), 32'(want.cluster));
            if (got.skipped !== want.skipped)
                report_mismatch("skipped", 32'(got.skipped), 32'(want.skipped));
            if (got.x !== want.x) report_mismatch("out_x", got.x, want.x);
            if (got.y !== want.y) report_mismatch("out_y", got.y, want.y);
            if (got.z !== want.z) report_mismatch("out_z", got.z, want.z);
            if (got.run_end !== want.run_end)
                report_mismatch("run_end", 32'(got.run_end), 32'(want.run_end));
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [3:0] cfg_wdata = '0;
    logic start = 0;
    logic busy;
    logic command = okmu_pkg::CMD_LOAD;
    logic [2:0] center_index = '0;
    logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
    logic last_point = 0;
    logic valid, kind, skipped, run_end;
    logic [2:0] cluster;
    logic signed [31:0] out_x, out_y, out_z;

    kmeans_scoreboard sb = new();
    bit idling_on = 1;

    online_kmeans_update_core DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .start(start), .busy(busy), .command(command), .center_index(center_index),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .last_point(last_point),
        .valid(valid), .kind(kind), .cluster(cluster), .skipped(skipped),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .run_end(run_end)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n && valid)
            sb.check_result({kind, cluster, skipped, out_x, out_y, out_z, run_end});
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Hold one beat on the command port until it is taken; start stays high
    // after the accepting edge until the next beat or an idle gap drops it.
    task automatic send_beat(input logic cmd, input logic [2:0] idx, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z, input logic lastp);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        center_index <= idx;
        coord_x <= x; coord_y <= y; coord_z <= z;
        last_point <= lastp;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_input(cmd, idx, x, y, z, lastp);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_count(input logic [3:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_count(v);
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 8'hFF)) - 128) <<< $urandom_range(0, 20);
        endcase
    endfunction

    // Load every center so nothing unwritten is ever compared.
    task automatic load_all();
        for (int i = 0; i < 8; i++)
            send_beat(okmu_pkg::CMD_LOAD, 3'(i), rand_coord($urandom_range(0, 2)),
                      rand_coord($urandom_range(0, 2)), rand_coord($urandom_range(0, 2)), 1'b0);
    endtask

    task automatic random_pass(input int n);
        int m;
        for (int i = 0; i < n; i++) begin
            m = $urandom_range(0, 9);
            if (m == 0)
                send_beat(okmu_pkg::CMD_LOAD, 3'($urandom_range(0, 7)), rand_coord(2),
                          rand_coord(2), rand_coord(2), 1'($urandom_range(0, 1)));
            else if (m == 1)
                // replay a starting center to hit the skip path
                begin
                    int j;
                    j = $urandom_range(0, 7);
                    send_beat(okmu_pkg::CMD_POINT, 3'($urandom()), sb.start_c[j][0],
                              sb.start_c[j][1], sb.start_c[j][2], 1'b0);
                end
            else
                send_beat(okmu_pkg::CMD_POINT, 3'($urandom()), rand_coord($urandom_range(0, 2)),
                          rand_coord($urandom_range(0, 2)), rand_coord($urandom_range(0, 2)),
                          1'b0);
        end
        send_beat(okmu_pkg::CMD_POINT, 3'($urandom()), rand_coord(2), rand_coord(2),
                  rand_coord(2), 1'b1);
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, skip, tie, last point, load ignoring last_point
        load_all();
        send_beat(okmu_pkg::CMD_LOAD, 3'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_beat(okmu_pkg::CMD_LOAD, 3'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_beat(okmu_pkg::CMD_POINT, 3'd5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_beat(okmu_pkg::CMD_POINT, 3'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 1'b0);
        send_beat(okmu_pkg::CMD_POINT, 3'd0, 32'h8000_0001, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_beat(okmu_pkg::CMD_POINT, 3'd0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 1'b0);
        send_beat(okmu_pkg::CMD_POINT, 3'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1);
        drain();

        // tie: two centers equidistant from a point between them
        write_count(4'd2);
        send_beat(okmu_pkg::CMD_LOAD, 3'd0, 32'd10, 32'd0, 32'd0, 1'b0);
        send_beat(okmu_pkg::CMD_LOAD, 3'd1, -32'sd10, 32'd0, 32'd0, 1'b0);
        send_beat(okmu_pkg::CMD_POINT, 3'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        send_beat(okmu_pkg::CMD_POINT, 3'd0, 32'd10, 32'd0, 32'd0, 1'b1);
        drain();

        // sweep settings, including out-of-range ones
        for (int s = 0; s < 6; s++) begin
            case (s)
                0: write_count(4'd0);
                1: write_count(4'd1);
                2: write_count(4'd15);
                3: write_count(4'd5);
                4: write_count(4'd3);
                default: write_count(4'd8);
            endcase
            random_pass(28);
            drain();
        end

        idling_on = 0;
        random_pass(20);
        drain();

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
